[rtl/bfdh_pkg.sv]
// Shared types and constants of the double-hash Bloom filter.
package bfdh_pkg;

    localparam int unsigned HASH_W    = 64;
    localparam int unsigned MIX_SHIFT = 33;
    localparam logic [HASH_W-1:0] MIX_MULT = 64'hff51afd7ed558ccd;
    localparam int unsigned BIT_W     = 6;    // bit select within a 64-bit word
    localparam int unsigned RES_W     = 23;   // residues mod filter size, widest build
    localparam int unsigned K_W       = 7;    // probe count, widest build
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned ONES_W    = 17;
    localparam int unsigned HC_W      = 5;
    localparam int unsigned WC_W      = 11;

    // Register indexes of the configuration port
    localparam logic CFG_HASH_COUNT = 1'b0;
    localparam logic CFG_WORD_COUNT = 1'b1;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Classified request handed from the front to the back
    typedef struct packed {
        t_req              req;
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
        logic [RES_W-1:0]  r0;   // h1 mod N
        logic [RES_W-1:0]  s;    // h2 mod N
        logic [RES_W-1:0]  m;    // 2^64 mod N
        logic [RES_W-1:0]  n;    // filter size in bits
        logic [K_W-1:0]    k;
    } t_work;

    typedef struct packed {
        logic              may_contain;
        logic [CNT_W-1:0]  inserted;
        logic [ONES_W-1:0] ones;
    } t_result;

endpackage

[rtl/bfdh_fifo.sv]
// Two-entry queue used between front and back and on the result side.
module bfdh_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 2'd1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule

[rtl/bfdh_front.sv]
// Front end: takes requests, derives h2 and the residues modulo the filter size.
module bfdh_front #(
    parameter int unsigned MAX_WORDS  = 1024,
    parameter int unsigned MAX_HASHES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_ready,
    input  logic [1:0]              i_req_type,
    input  logic [63:0]             i_hash_value,
    input  logic [bfdh_pkg::HC_W-1:0] i_hash_count,
    input  logic [bfdh_pkg::WC_W-1:0] i_word_count,
    output logic                    o_wvalid,
    output bfdh_pkg::t_work         o_work,
    input  logic                    i_wfull
);
    import bfdh_pkg::*;

    localparam int unsigned NW        = $clog2(MAX_WORDS * 64) + 1;
    localparam int unsigned WW        = NW - BIT_W;
    localparam int unsigned DIV_BITS  = 4;
    localparam int unsigned DIV_STEPS = HASH_W / DIV_BITS;
    localparam int unsigned SW        = $clog2(DIV_STEPS);
    localparam logic [ONES_W-1:0] MAXW = ONES_W'(MAX_WORDS);
    localparam logic [K_W-1:0]    MAXK = K_W'(MAX_HASHES);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_PUSH} t_state;

    t_state            r_state;
    t_req              r_req;
    logic [HASH_W-1:0] r_h1;
    logic [HASH_W-1:0] r_t;
    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] r_prod;
    logic [HASH_W-1:0] r_h2;
    logic [HASH_W-1:0] r_d1;
    logic [HASH_W-1:0] r_d2;
    logic [NW-1:0]     r_n;
    logic [NW-1:0]     r_r1;
    logic [NW-1:0]     r_r2;
    logic [NW-1:0]     r_rm;
    logic [K_W-1:0]    r_k;
    logic [SW-1:0]     r_cnt;

    logic [NW-1:0]     n_r1;
    logic [NW-1:0]     n_r2;
    logic [NW-1:0]     n_rm;
    logic [HASH_W-1:0] n_d1;
    logic [HASH_W-1:0] n_d2;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [HASH_W-1:0] acc_fin;
    logic [ONES_W-1:0] wc_ext;
    logic [WW-1:0]     w_eff;
    logic [K_W-1:0]    k_eff;
    logic [NW-1:0]     m_inc;
    logic [NW-1:0]     m_val;

    assign o_ready  = (r_state == S_IDLE);
    assign o_wvalid = (r_state == S_PUSH);

    // clamp configuration to the meaningful range
    assign wc_ext = ONES_W'(i_word_count);
    always_comb begin
        if (wc_ext == '0)      w_eff = WW'(1);
        else if (wc_ext > MAXW) w_eff = WW'(MAX_WORDS);
        else                    w_eff = WW'(wc_ext);
        if (i_hash_count == '0)                  k_eff = K_W'(1);
        else if (K_W'(i_hash_count) > MAXK)      k_eff = MAXK;
        else                                     k_eff = K_W'(i_hash_count);
    end

    // 32x32 partial products of t * MIX_MULT, low 64 bits only
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin mul_a = r_t[31:0];  mul_b = MIX_MULT[31:0];  end
            2'd1:    begin mul_a = r_t[31:0];  mul_b = MIX_MULT[63:32]; end
            default: begin mul_a = r_t[63:32]; mul_b = MIX_MULT[31:0];  end
        endcase
    end
    assign acc_fin = r_acc + {r_prod[31:0], 32'd0};

    // restoring remainder, DIV_BITS dividend bits per cycle for three values
    always_comb begin
        logic [NW-1:0] t1;
        logic [NW-1:0] t2;
        logic [NW-1:0] t3;
        n_r1 = r_r1;
        n_r2 = r_r2;
        n_rm = r_rm;
        n_d1 = r_d1;
        n_d2 = r_d2;
        for (int j = 0; j < DIV_BITS; j++) begin
            t1 = {n_r1[NW-2:0], n_d1[HASH_W-1]};
            t2 = {n_r2[NW-2:0], n_d2[HASH_W-1]};
            t3 = {n_rm[NW-2:0], 1'b1};
            n_r1 = (t1 >= r_n) ? t1 - r_n : t1;
            n_r2 = (t2 >= r_n) ? t2 - r_n : t2;
            n_rm = (t3 >= r_n) ? t3 - r_n : t3;
            n_d1 = {n_d1[HASH_W-2:0], 1'b0};
            n_d2 = {n_d2[HASH_W-2:0], 1'b0};
        end
    end

    // 2^64 mod N from (2^64 - 1) mod N
    assign m_inc = r_rm + NW'(1);
    assign m_val = (m_inc == r_n) ? '0 : m_inc;

    always_comb begin
        o_work     = '0;
        o_work.req = r_req;
        o_work.h1  = r_h1;
        o_work.h2  = r_h2;
        o_work.r0  = RES_W'(r_r1);
        o_work.s   = RES_W'(r_r2);
        o_work.m   = RES_W'(m_val);
        o_work.n   = RES_W'(r_n);
        o_work.k   = r_k;
    end

    // sequencer: multiply, then divide, then hand over; clear and other requests hand over at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_req <= t_req'(i_req_type);
                        r_h1  <= i_hash_value;
                        r_t   <= i_hash_value ^ (i_hash_value >> MIX_SHIFT);
                        r_n   <= {w_eff, {BIT_W{1'b0}}};
                        r_k   <= k_eff;
                        r_h2  <= '0;
                        r_r1  <= '0;
                        r_r2  <= '0;
                        r_rm  <= '0;
                        r_cnt <= '0;
                        if (i_req_type == REQ_INSERT || i_req_type == REQ_QUERY)
                            r_state <= S_MUL;
                        else
                            r_state <= S_PUSH;
                    end
                end
                S_MUL: begin
                    r_prod <= mul_a * mul_b;
                    if (r_cnt[1:0] == 2'd3) r_cnt <= '0;
                    else                    r_cnt <= r_cnt + SW'(1);
                    case (r_cnt[1:0])
                        2'd0:    r_acc <= '0;
                        2'd1:    r_acc <= r_prod;
                        2'd2:    r_acc <= acc_fin;
                        default: begin
                            r_h2    <= acc_fin ^ (acc_fin >> MIX_SHIFT);
                            r_d2    <= acc_fin ^ (acc_fin >> MIX_SHIFT);
                            r_d1    <= r_h1;
                            r_state <= S_DIV;
                        end
                    endcase
                end
                S_DIV: begin
                    r_r1  <= n_r1;
                    r_r2  <= n_r2;
                    r_rm  <= n_rm;
                    r_d1  <= n_d1;
                    r_d2  <= n_d2;
                    r_cnt <= r_cnt + SW'(1);
                    if (r_cnt == SW'(DIV_STEPS - 1)) r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_wfull) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/bfdh_back.sv]
// Back end: bit array, probe read-modify-write, clear sweeps and counters.
module bfdh_back #(
    parameter int unsigned MAX_WORDS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wempty,
    output logic              o_wpop,
    input  bfdh_pkg::t_work   i_work,
    output logic              o_rvalid,
    output bfdh_pkg::t_result o_result,
    input  logic              i_rfull,
    output logic              o_init
);
    import bfdh_pkg::*;

    localparam int unsigned NW = $clog2(MAX_WORDS * 64) + 1;
    localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam logic [AW-1:0] LAST = AW'(MAX_WORDS - 1);

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_RD, S_CHK, S_CLR, S_OUT} t_state;

    logic [63:0]       r_mem [MAX_WORDS];
    logic [63:0]       r_rdata;
    t_state            r_state;
    t_req              r_req;
    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] r_h2;
    logic [NW-1:0]     r_idx;
    logic [NW-1:0]     r_s;
    logic [NW-1:0]     r_m;
    logic [NW-1:0]     r_n;
    logic [K_W-1:0]    r_left;
    logic              r_hit;
    logic [AW-1:0]     r_caddr;
    logic [CNT_W-1:0]  r_inserted;
    logic [ONES_W-1:0] r_ones;
    t_result           r_res;

    logic [AW-1:0]     word_addr;
    logic              bit_set;
    logic [63:0]       bit_mask;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [63:0]       mem_wd;
    logic [HASH_W:0]   acc_sum;
    logic [NW-1:0]     idx_a;
    logic [NW-1:0]     idx_b;
    logic [NW-1:0]     idx_next;
    logic              new_one;
    logic [ONES_W-1:0] ones_inc;

    assign o_init   = (r_state == S_INIT);
    assign o_rvalid = (r_state == S_OUT);
    assign o_result = r_res;
    assign o_wpop   = (r_state == S_IDLE) && !i_wempty;

    assign word_addr = r_idx[BIT_W +: AW];
    assign bit_mask  = 64'd1 << r_idx[BIT_W-1:0];
    assign bit_set   = r_rdata[r_idx[BIT_W-1:0]];
    assign new_one   = (r_req == REQ_INSERT) && !bit_set;
    assign ones_inc  = (r_ones == '1) ? r_ones : r_ones + ONES_W'(1);

    // next probe: idx += h2 mod 2^64, tracked mod N; a wrap takes off 2^64 mod N
    assign acc_sum = {1'b0, r_acc} + {1'b0, r_h2};
    always_comb begin
        idx_a = r_idx + r_s;
        if (idx_a >= r_n) idx_a = idx_a - r_n;
        if (!acc_sum[HASH_W])  idx_b = idx_a;
        else if (idx_a >= r_m) idx_b = idx_a - r_m;
        else                   idx_b = idx_a + r_n - r_m;
        idx_next = idx_b;
    end

    // memory write port: sweeps write zero, inserts write the updated word
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_caddr;
        mem_wd = '0;
        if (r_state == S_INIT || r_state == S_CLR) begin
            mem_we = 1'b1;
        end else if (r_state == S_CHK && new_one) begin
            mem_we = 1'b1;
            mem_wa = word_addr;
            mem_wd = r_rdata | bit_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[word_addr];
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_caddr    <= '0;
            r_inserted <= '0;
            r_ones     <= '0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    if (r_caddr == LAST) begin
                        r_caddr <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_caddr <= r_caddr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (!i_wempty) begin
                        r_req  <= i_work.req;
                        r_acc  <= i_work.h1;
                        r_h2   <= i_work.h2;
                        r_idx  <= NW'(i_work.r0);
                        r_s    <= NW'(i_work.s);
                        r_m    <= NW'(i_work.m);
                        r_n    <= NW'(i_work.n);
                        r_left <= i_work.k;
                        r_hit  <= 1'b1;
                        unique case (i_work.req) inside
                            REQ_INSERT, REQ_QUERY: r_state <= S_RD;
                            REQ_CLEAR: begin
                                r_caddr <= '0;
                                r_state <= S_CLR;
                            end
                            default: begin
                                r_res   <= '{1'b0, r_inserted, r_ones};
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    r_acc  <= acc_sum[HASH_W-1:0];
                    r_idx  <= idx_next;
                    r_left <= r_left - K_W'(1);
                    if (!bit_set) r_hit <= 1'b0;
                    if (new_one)  r_ones <= ones_inc;
                    if (r_left == K_W'(1)) begin
                        if (r_req == REQ_INSERT) begin
                            r_inserted <= r_inserted + CNT_W'(1);
                            r_res <= '{1'b0, r_inserted + CNT_W'(1),
                                       new_one ? ones_inc : r_ones};
                        end else begin
                            r_res <= '{r_hit & bit_set, r_inserted, r_ones};
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_CLR: begin
                    if (r_caddr == LAST) begin
                        r_caddr    <= '0;
                        r_inserted <= '0;
                        r_ones     <= '0;
                        r_res      <= '{1'b0, {CNT_W{1'b0}}, {ONES_W{1'b0}}};
                        r_state    <= S_OUT;
                    end else begin
                        r_caddr <= r_caddr + AW'(1);
                    end
                end
                S_OUT: begin
                    if (!i_rfull) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/bloom_filter_double_hash_core.sv]
// Bloom filter with double hashing: front end, work queue, back end, result queue.
// The front end runs 4 multiply steps, then 16 remainder steps at 4 bits a cycle;
// the back end does one array read-modify-write per probe, and a clear sweeps
// the array one word a cycle. Through the work queue, the front end can take a
// new request while the back end is still working on earlier ones.
// Reset: synchronous; afterwards the array is swept to zero word by word,
// during which full stays high. Configuration resets to k = 2, 1024 words.
module bloom_filter_double_hash_core #(
    parameter int unsigned MAX_WORDS  = 1024,
    parameter int unsigned MAX_HASHES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [bfdh_pkg::WC_W-1:0]   i_cfg_wdata,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_req_type,
    input  logic [63:0]                 i_hash_value,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_may_contain,
    output logic [bfdh_pkg::CNT_W-1:0]  o_inserted_total,
    output logic [bfdh_pkg::ONES_W-1:0] o_set_bit_total
);
    import bfdh_pkg::*;

    logic [HC_W-1:0] r_hash_count;
    logic [WC_W-1:0] r_word_count;
    logic            front_ready;
    logic            init_busy;
    logic            work_valid;
    t_work           work_in;
    t_work           work_out;
    logic            work_full;
    logic            work_empty;
    logic            work_pop;
    logic            res_valid;
    t_result         res_in;
    t_result         res_out;
    logic            res_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count <= HC_W'(2);
            r_word_count <= WC_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HASH_COUNT: r_hash_count <= i_cfg_wdata[HC_W-1:0];
                default:        r_word_count <= i_cfg_wdata;
            endcase
        end
    end

    assign full = !front_ready || init_busy;

    bfdh_front #(
        .MAX_WORDS  (MAX_WORDS),
        .MAX_HASHES (MAX_HASHES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push && !init_busy),
        .o_ready      (front_ready),
        .i_req_type   (i_req_type),
        .i_hash_value (i_hash_value),
        .i_hash_count (r_hash_count),
        .i_word_count (r_word_count),
        .o_wvalid     (work_valid),
        .o_work       (work_in),
        .i_wfull      (work_full)
    );

    bfdh_fifo #(
        .WIDTH ($bits(t_work))
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_valid),
        .i_data  (work_in),
        .o_full  (work_full),
        .i_pop   (work_pop),
        .o_empty (work_empty),
        .o_data  (work_out)
    );

    bfdh_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wempty (work_empty),
        .o_wpop   (work_pop),
        .i_work   (work_out),
        .o_rvalid (res_valid),
        .o_result (res_in),
        .i_rfull  (res_full),
        .o_init   (init_busy)
    );

    bfdh_fifo #(
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_may_contain    = res_out.may_contain;
    assign o_inserted_total = res_out.inserted;
    assign o_set_bit_total  = res_out.ones;
endmodule

[bench/bfdh_scoreboard.sv]
// Checker for the Bloom filter core: watches the ports, predicts every result and compares.
`timescale 1ns / 1ps

module bfdh_scoreboard #(
    parameter int unsigned MAX_WORDS  = 1024,
    parameter int unsigned MAX_HASHES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [bfdh_pkg::WC_W-1:0]   i_cfg_wdata,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic [1:0]                  i_req_type,
    input  logic [63:0]                 i_hash_value,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  logic                        i_may_contain,
    input  logic [bfdh_pkg::CNT_W-1:0]  i_inserted_total,
    input  logic [bfdh_pkg::ONES_W-1:0] i_set_bit_total,
    output int                          o_errors,
    output int                          o_pending
);
    import bfdh_pkg::*;

    // Shadow copy of the filter state and its configuration
    logic [63:0]       filter_bits [MAX_WORDS];
    logic [CNT_W-1:0]  insert_cnt;
    logic [ONES_W-1:0] ones_cnt;
    logic [HC_W-1:0]   probe_reg;
    logic [WC_W-1:0]   word_reg;
    t_result           expected_q [$];

    // Second hash: shift-xor, multiply, shift-xor
    function automatic logic [63:0] mix_hash(input logic [63:0] h1);
        logic [63:0] t;
        t = h1 ^ (h1 >> MIX_SHIFT);
        t = t * MIX_MULT;
        return t ^ (t >> MIX_SHIFT);
    endfunction

    // Apply one request to the shadow state and queue the result it yields
    task automatic apply_request(input t_req req, input logic [63:0] h1);
        t_result     r;
        logic [63:0] h2;
        logic [63:0] pos;
        logic [63:0] nbits;
        logic [63:0] word;
        int unsigned k;
        logic        hit;
        r = '0;
        if (req == REQ_INSERT || req == REQ_QUERY) begin
            h2 = mix_hash(h1);
            k = (probe_reg == 0) ? 1 : (probe_reg > MAX_HASHES) ? MAX_HASHES : probe_reg;
            nbits = (word_reg == 0) ? 64 :
                    (word_reg > MAX_WORDS) ? 64'(MAX_WORDS) * 64 : 64'(word_reg) * 64;
            hit = 1'b1;
            for (int unsigned i = 0; i < k; i++) begin
                pos  = (h1 + 64'(i) * h2) % nbits;
                word = pos >> 6;
                if (!filter_bits[word][pos[5:0]]) begin
                    hit = 1'b0;
                    if (req == REQ_INSERT) begin
                        filter_bits[word][pos[5:0]] = 1'b1;
                        if (ones_cnt != '1) ones_cnt++;
                    end
                end
            end
            if (req == REQ_INSERT) insert_cnt++;
            else r.may_contain = hit;
        end else if (req == REQ_CLEAR) begin
            foreach (filter_bits[w]) filter_bits[w] = '0;
            insert_cnt = '0;
            ones_cnt   = '0;
        end
        r.inserted = insert_cnt;
        r.ones     = ones_cnt;
        expected_q.push_back(r);
    endtask

    // Result transfer first, then configuration and request transfers
    always @(posedge i_clk) begin : watch
        t_result exp_r;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            foreach (filter_bits[w]) filter_bits[w] = '0;
            insert_cnt = '0;
            ones_cnt   = '0;
            probe_reg  = 5'd2;
            word_reg   = 11'd1024;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    bad++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_may_contain !== exp_r.may_contain) begin
                        $error("may_contain: expected %0d, got %0d",
                               exp_r.may_contain, i_may_contain);
                        bad++;
                    end
                    if (i_inserted_total !== exp_r.inserted) begin
                        $error("inserted_total: expected %0d, got %0d",
                               exp_r.inserted, i_inserted_total);
                        bad++;
                    end
                    if (i_set_bit_total !== exp_r.ones) begin
                        $error("set_bit_total: expected %0d, got %0d",
                               exp_r.ones, i_set_bit_total);
                        bad++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_HASH_COUNT) probe_reg = i_cfg_wdata[HC_W-1:0];
                else word_reg = i_cfg_wdata;
            end
            if (i_push && !i_full) apply_request(t_req'(i_req_type), i_hash_value);
            if (bad != 0) o_errors <= o_errors + bad;
        end
        o_pending <= expected_q.size();
    end

endmodule

[bench/bloom_filter_double_hash_core_tb.sv]
// Top of the Bloom filter bench: clock, reset, stimulus, result draining and verdict.
`timescale 1ns / 1ps

module bloom_filter_double_hash_core_tb;
    import bfdh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 10000000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 300;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_addr = 1'b0;
    logic [WC_W-1:0]   i_cfg_wdata = '0;
    logic              push = 1'b0;
    logic              full;
    logic [1:0]        i_req_type = '0;
    logic [63:0]       i_hash_value = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_may_contain;
    logic [CNT_W-1:0]  o_inserted_total;
    logic [ONES_W-1:0] o_set_bit_total;

    int          errors;
    int          pending;
    int unsigned cycles = 0;
    bit          idle_en = 1'b1;
    bit          long_hold = 1'b0;
    logic [63:0] key_pool [$];

    always #5 i_clk = ~i_clk;

    bloom_filter_double_hash_core dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .push, .full, .i_req_type, .i_hash_value,
        .empty, .pop, .o_may_contain, .o_inserted_total, .o_set_bit_total
    );

    bfdh_scoreboard scoreboard (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_push(push), .i_full(full), .i_req_type, .i_hash_value,
        .i_empty(empty), .i_pop(pop), .i_may_contain(o_may_contain),
        .i_inserted_total(o_inserted_total), .i_set_bit_total(o_set_bit_total),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                pop <= 1'b0;
                repeat (800) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // One request transfer, with an optional gap before it
    task automatic send_req(input t_req req, input logic [63:0] h);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_req_type   <= req;
        i_hash_value <= h;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering and wait for every result, then let the block settle
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || !empty);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [WC_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_filter(input logic [WC_W-1:0] probes, input logic [WC_W-1:0] words);
        drain();
        write_reg(CFG_HASH_COUNT, probes);
        write_reg(CFG_WORD_COUNT, words);
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        logic [63:0] h;
        int unsigned sel;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset configuration, extremes of the key, unused code, clear
        send_req(REQ_INSERT, 64'h0);
        send_req(REQ_QUERY, 64'h0);
        send_req(REQ_QUERY, '1);
        send_req(REQ_INSERT, '1);
        send_req(REQ_QUERY, '1);
        send_req(REQ_NONE, rand_key());
        send_req(REQ_CLEAR, rand_key());
        send_req(REQ_QUERY, 64'h0);
        // Probe and word counts of zero act as one
        set_filter(11'd0, 11'd0);
        send_req(REQ_INSERT, 64'h1234_5678_9abc_def0);
        send_req(REQ_QUERY, 64'h1234_5678_9abc_def0);
        send_req(REQ_QUERY, 64'h8000_0000_0000_0001);
        // Counts above the maximum clamp; high bits of the probe write are dropped
        set_filter(11'h7ff, 11'h7ff);
        send_req(REQ_INSERT, '1);
        send_req(REQ_QUERY, '1);
        set_filter(11'd16, 11'd1024);
        send_req(REQ_INSERT, 64'hdead_beef_0000_0001);
        send_req(REQ_INSERT, 64'h0123_4567_89ab_cdef);
        // Shrinking keeps the old bits counted; clear wipes every word
        set_filter(11'd3, 11'd1);
        send_req(REQ_QUERY, 64'hdead_beef_0000_0001);
        send_req(REQ_INSERT, 64'h5555_aaaa_5555_aaaa);
        send_req(REQ_CLEAR, 64'h0);
        set_filter(11'd16, 11'd1024);
        send_req(REQ_QUERY, 64'h0123_4567_89ab_cdef);
        send_req(REQ_INSERT, 64'h0123_4567_89ab_cdef);

        // Random phases, each under a fresh configuration
        for (int p = 0; p < PHASES; p++) begin
            set_filter({6'($urandom_range(0, 63)), 5'($urandom_range(0, 31))},
                       ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                   : 11'($urandom_range(0, 8)));
            key_pool.delete();
            if (p == PHASES - 1) idle_en = 1'b0;
            if (p == 2) begin
                idle_en   = 1'b0;
                long_hold = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 80) idle_en = 1'b1;
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    h = rand_key();
                    send_req(REQ_INSERT, h);
                    if (key_pool.size() >= 64) void'(key_pool.pop_front());
                    key_pool.push_back(h);
                end else if (sel < 80 && key_pool.size() != 0) begin
                    send_req(REQ_QUERY, key_pool[$urandom_range(0, key_pool.size() - 1)]);
                end else if (sel < 84) begin
                    send_req(REQ_CLEAR, rand_key());
                    key_pool.delete();
                end else if (sel < 88) begin
                    send_req(REQ_NONE, rand_key());
                end else begin
                    send_req(REQ_QUERY, rand_key());
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[bloom_filter_double_hash_core.f]
rtl/bfdh_pkg.sv
rtl/bfdh_fifo.sv
rtl/bfdh_front.sv
rtl/bfdh_back.sv
rtl/bloom_filter_double_hash_core.sv
bench/bfdh_scoreboard.sv
bench/bloom_filter_double_hash_core_tb.sv
